>>> hw/rtl/sdci_pkg.sv
// ----------------------------------------------------------------------------
// SD card init sequencer package
// Step codes, command constants, register indexes and the structs that pass
// between the sequencer's top level and its step logic.
// ----------------------------------------------------------------------------
package sdci_pkg;

	// Sequencer steps. Most steps name the command whose completion they await.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'd0,
		ST_CMD0  = 5'd1,
		ST_CMD8  = 5'd2,
		ST_P55   = 5'd3,
		ST_A41   = 5'd4,
		ST_CMD58 = 5'd5,
		ST_CMD2  = 5'd6,
		ST_CMD3  = 5'd7,
		ST_CMD9  = 5'd8,
		ST_CMD7  = 5'd9,
		ST_CMD16 = 5'd10,
		ST_B55   = 5'd11,
		ST_A6    = 5'd12,
		ST_S55   = 5'd13,
		ST_A51   = 5'd14,
		ST_SCRW  = 5'd15,
		ST_FINAL = 5'd16
	} step_t;

	// Input event codes.
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_DONE  = 2'd1;
	localparam logic [1:0] ACT_DATA  = 2'd2;
	localparam logic [1:0] ACT_TICK  = 2'd3;

	// Command completion status codes.
	localparam logic [1:0] STS_OK  = 2'd0;
	localparam logic [1:0] STS_CRC = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_SCR    = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	// Finish codes.
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CRC  = 2'd1;
	localparam logic [1:0] ERR_CARD = 2'd2;
	localparam logic [1:0] ERR_DAT  = 2'd3;

	// Command indexes.
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_ALL_CID   = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
	localparam logic [5:0] ACMD_BUS_W    = 6'd6;
	localparam logic [5:0] CMD_SELECT    = 6'd7;
	localparam logic [5:0] CMD_IF_COND   = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
	localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
	localparam logic [5:0] ACMD_OP_COND  = 6'd41;
	localparam logic [5:0] ACMD_SEND_SCR = 6'd51;
	localparam logic [5:0] CMD_APP       = 6'd55;
	localparam logic [5:0] CMD_READ_OCR  = 6'd58;

	// Command arguments and response bit positions.
	localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
	localparam logic [31:0] OP_COND_ARG = 32'h4030_0000;
	localparam logic [31:0] BLOCK_LEN   = 32'd512;
	localparam logic [31:0] BUS_W4_ARG  = 32'd2;
	localparam int          READY_POS   = 31;
	localparam int          CCS_POS     = 30;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 20;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_SELECT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDE_BUS      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPT_LIMIT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WAIT_LIMIT    = 2'd3;
	localparam logic [7:0]  ATTEMPT_LIMIT_RST = 8'd200;
	localparam logic [19:0] WAIT_LIMIT_RST    = 20'd100000;

	typedef struct packed {
		logic        wide_bus;
		logic [7:0]  attempt_limit;
		logic [19:0] wait_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  cmd_status;
		logic [31:0] response_word;
		logic [31:0] data_word;
	} item_t;

	typedef struct packed {
		step_t       step;
		logic [7:0]  attempts;
		logic [19:0] wait_count;
		logic [31:0] ocr;
		logic        ccs;
		logic [15:0] rca;
		logic        scr_half;
	} seq_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		logic        apply_clock;
		logic [31:0] word_out;
		logic [1:0]  error_code;
		logic        high_capacity;
		logic [31:0] ocr_value;
		logic [15:0] card_address;
	} result_t;

endpackage

>>> hw/rtl/sdci_channels.sv
// ----------------------------------------------------------------------------
// SD card init sequencer channels
// Valid/ready channels for incoming events and outgoing results.
// ----------------------------------------------------------------------------
interface sdci_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  cmd_status;
	logic [31:0] response_word;
	logic [31:0] data_word;

	modport source (output valid, action, cmd_status, response_word, data_word,
		input ready);
	modport sink (input valid, action, cmd_status, response_word, data_word,
		output ready);
endinterface

interface sdci_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  cmd_index;
	logic [31:0] cmd_argument;
	logic        apply_clock;
	logic [31:0] word_out;
	logic [1:0]  error_code;
	logic        high_capacity;
	logic [31:0] ocr_value;
	logic [15:0] card_address;

	modport source (output valid, kind, cmd_index, cmd_argument, apply_clock, word_out,
		error_code, high_capacity, ocr_value, card_address, input ready);
	modport sink (input valid, kind, cmd_index, cmd_argument, apply_clock, word_out,
		error_code, high_capacity, ocr_value, card_address, output ready);
endinterface

>>> hw/rtl/sdci_step.sv
// ----------------------------------------------------------------------------
// SD card init sequencer step logic
// Combinational transition: from one event and the current sequencer state,
// forms the next state and at most one result beat.
// ----------------------------------------------------------------------------
module sdci_step import sdci_pkg::*; (
	input  item_t      item,
	input  seq_state_t cur,
	input  cfg_t       cfg,
	output seq_state_t nxt,
	output logic       has_result,
	output result_t    res
);

	logic        ok;
	logic        crc;
	logic [7:0]  att_inc;
	logic [31:0] rarg;

	// Status decode; any status other than ok or CRC behaves as a timeout.
	assign ok  = (item.cmd_status == STS_OK);
	assign crc = (item.cmd_status == STS_CRC);

	// The attempt counter saturates at its maximum.
	assign att_inc = (cur.attempts != 8'hFF) ? cur.attempts + 8'd1 : cur.attempts;

	// Addressed commands carry the RCA in the upper half of the argument.
	assign rarg = {cur.rca, 16'h0000};

	always_comb begin
		nxt              = cur;
		has_result       = 1'b0;
		res.kind         = KIND_CMD;
		res.cmd_index    = '0;
		res.cmd_argument = '0;
		res.apply_clock  = 1'b0;
		res.word_out     = '0;
		res.error_code   = ERR_NONE;

		case (item.action)
			// A start clears everything and issues the reset command.
			ACT_START: begin
				nxt.step       = ST_CMD0;
				nxt.attempts   = '0;
				nxt.wait_count = '0;
				nxt.ocr        = '0;
				nxt.ccs        = 1'b0;
				nxt.rca        = '0;
				nxt.scr_half   = 1'b0;
				has_result     = 1'b1;
				res.cmd_index  = CMD_GO_IDLE;
			end

			// A command completion advances the command sequence.
			ACT_DONE: begin
				has_result = 1'b1;
				case (cur.step)
					ST_CMD0: begin
						nxt.step         = ST_CMD8;
						res.cmd_index    = CMD_IF_COND;
						res.cmd_argument = IF_COND_ARG;
					end
					ST_CMD8: begin
						if (crc) begin
							nxt.step       = ST_IDLE;
							res.kind       = KIND_FINISH;
							res.error_code = ERR_CRC;
						end else begin
							nxt.step      = ST_P55;
							res.cmd_index = CMD_APP;
							res.word_out  = ok ? item.response_word : '0;
						end
					end
					ST_P55: begin
						nxt.step         = ST_A41;
						res.cmd_index    = ACMD_OP_COND;
						res.cmd_argument = OP_COND_ARG;
					end
					ST_A41: begin
						nxt.attempts = att_inc;
						if (crc) begin
							nxt.step       = ST_IDLE;
							res.kind       = KIND_FINISH;
							res.error_code = ERR_CRC;
						end else if (ok && item.response_word[READY_POS]) begin
							nxt.step      = ST_CMD58;
							res.cmd_index = CMD_READ_OCR;
						end else if (att_inc < cfg.attempt_limit) begin
							nxt.step      = ST_P55;
							res.cmd_index = CMD_APP;
						end else begin
							nxt.step       = ST_IDLE;
							res.kind       = KIND_FINISH;
							res.error_code = ERR_CARD;
						end
					end
					ST_CMD58: begin
						nxt.ocr = ok ? item.response_word : '0;
						nxt.ccs = ok & item.response_word[CCS_POS];
						if (crc) begin
							nxt.step       = ST_IDLE;
							res.kind       = KIND_FINISH;
							res.error_code = ERR_CRC;
						end else begin
							nxt.step        = ST_CMD2;
							res.cmd_index   = CMD_ALL_CID;
							res.apply_clock = 1'b1;
						end
					end
					ST_CMD2: begin
						if (crc) begin
							nxt.step       = ST_IDLE;
							res.kind       = KIND_FINISH;
							res.error_code = ERR_CRC;
						end else begin
							nxt.step      = ST_CMD3;
							res.cmd_index = CMD_SEND_RCA;
						end
					end
					ST_CMD3: begin
						if (ok) begin
							nxt.rca = item.response_word[31:16];
						end
						if (crc) begin
							nxt.step       = ST_IDLE;
							res.kind       = KIND_FINISH;
							res.error_code = ERR_CRC;
						end else begin
							nxt.step         = ST_CMD9;
							res.cmd_index    = CMD_SEND_CSD;
							res.cmd_argument = {nxt.rca, 16'h0000};
						end
					end
					ST_CMD9: begin
						if (crc) begin
							nxt.step       = ST_IDLE;
							res.kind       = KIND_FINISH;
							res.error_code = ERR_CRC;
						end else begin
							nxt.step         = ST_CMD7;
							res.cmd_index    = CMD_SELECT;
							res.cmd_argument = rarg;
						end
					end
					ST_CMD7: begin
						// Standard capacity cards need the block length set.
						if (!cur.ccs) begin
							nxt.step         = ST_CMD16;
							res.cmd_index    = CMD_BLOCKLEN;
							res.cmd_argument = BLOCK_LEN;
						end else begin
							nxt.step         = ST_B55;
							res.cmd_index    = CMD_APP;
							res.cmd_argument = rarg;
						end
					end
					ST_CMD16: begin
						nxt.step         = ST_B55;
						res.cmd_index    = CMD_APP;
						res.cmd_argument = rarg;
					end
					ST_B55: begin
						nxt.step         = ST_A6;
						res.cmd_index    = ACMD_BUS_W;
						res.cmd_argument = cfg.wide_bus ? BUS_W4_ARG : '0;
					end
					ST_A6: begin
						nxt.step         = ST_S55;
						res.cmd_index    = CMD_APP;
						res.cmd_argument = rarg;
					end
					ST_S55: begin
						nxt.step      = ST_A51;
						res.cmd_index = ACMD_SEND_SCR;
					end
					ST_A51: begin
						// The SCR read starts; the data words bring the results.
						nxt.step       = ST_SCRW;
						nxt.wait_count = '0;
						nxt.scr_half   = 1'b0;
						has_result     = 1'b0;
					end
					default: begin
						has_result = 1'b0;
					end
				endcase
			end

			// Each SCR data word is forwarded and restarts the wait timer.
			ACT_DATA: begin
				if (cur.step == ST_SCRW) begin
					nxt.wait_count = '0;
					nxt.scr_half   = ~cur.scr_half;
					if (cur.scr_half) begin
						nxt.step = ST_FINAL;
					end
					has_result   = 1'b1;
					res.kind     = KIND_SCR;
					res.word_out = item.data_word;
				end
			end

			// Ticks time the SCR wait and close the sequence after the last word.
			default: begin
				if (cur.step == ST_FINAL) begin
					nxt.step       = ST_IDLE;
					has_result     = 1'b1;
					res.kind       = KIND_FINISH;
					res.error_code = ERR_NONE;
				end else if (cur.step == ST_SCRW) begin
					if (cur.wait_count >= cfg.wait_limit) begin
						nxt.step       = ST_IDLE;
						has_result     = 1'b1;
						res.kind       = KIND_FINISH;
						res.error_code = ERR_DAT;
					end else begin
						nxt.wait_count = cur.wait_count + 20'd1;
					end
				end
			end
		endcase

		// Every result reports the captured card registers after this event.
		res.high_capacity = nxt.ccs;
		res.ocr_value     = nxt.ocr;
		res.card_address  = nxt.rca;
	end

endmodule

>>> hw/rtl/sd_card_init_sequencer_core.sv
// ----------------------------------------------------------------------------
// SD card init sequencer core
// Events wait in the input register, result beats in the result register.
// Throughput: one event per cycle while the result side keeps taking beats;
// the bound is the single step of the sequencer state register.
// Reset clears the sequence state and the capture registers and returns the
// settings to their default values.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer_core import sdci_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	sdci_event_if.sink             events,
	sdci_result_if.source          results,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	item_t      item_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_nxt;
	cfg_t       cfg_q;
	result_t    res;
	result_t    res_q;
	logic       has_result;
	logic       out_valid_q;
	logic       out_free;
	logic       advance;

	// The held event moves on when the result register can take its beat.
	assign out_free      = !out_valid_q || results.ready;
	assign advance       = valid_s1 && out_free;
	assign events.ready  = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			item_s1.action        <= events.action;
			item_s1.cmd_status    <= events.cmd_status;
			item_s1.response_word <= events.response_word;
			item_s1.data_word     <= events.data_word;
		end
	end

	// Settings. A write to the clock speed code changes nothing in this block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_bus      <= 1'b0;
			cfg_q.attempt_limit <= ATTEMPT_LIMIT_RST;
			cfg_q.wait_limit    <= WAIT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDE_BUS:      cfg_q.wide_bus      <= cfg_data[0];
				REG_ATTEMPT_LIMIT: cfg_q.attempt_limit <= cfg_data[7:0];
				REG_WAIT_LIMIT:    cfg_q.wait_limit    <= cfg_data;
				REG_CLOCK_SELECT:  cfg_q.wide_bus      <= cfg_q.wide_bus;
				default:           cfg_q.wide_bus      <= cfg_q.wide_bus;
			endcase
		end
	end

	// Step logic.
	sdci_step u_step (
		.item       (item_s1),
		.cur        (state_q),
		.cfg        (cfg_q),
		.nxt        (state_nxt),
		.has_result (has_result),
		.res        (res)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step       <= ST_IDLE;
			state_q.attempts   <= '0;
			state_q.wait_count <= '0;
			state_q.ocr        <= '0;
			state_q.ccs        <= 1'b0;
			state_q.rca        <= '0;
			state_q.scr_half   <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.kind          = res_q.kind;
	assign results.cmd_index     = res_q.cmd_index;
	assign results.cmd_argument  = res_q.cmd_argument;
	assign results.apply_clock   = res_q.apply_clock;
	assign results.word_out      = res_q.word_out;
	assign results.error_code    = res_q.error_code;
	assign results.high_capacity = res_q.high_capacity;
	assign results.ocr_value     = res_q.ocr_value;
	assign results.card_address  = res_q.card_address;

	// A start event always yields the reset command on the next cycle.
	a_start_issues_cmd0: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.action == ACT_START |=>
		results.valid && results.kind == KIND_CMD && results.cmd_index == CMD_GO_IDLE)
		else $error("start event did not issue the reset command");

	// A held event waits unchanged while the result side is stalled.
	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(item_s1))
		else $error("held event lost during result stall");

	// Events are refused only while a held event waits on a full result register.
	a_ready_low_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!events.ready |-> valid_s1 && out_valid_q && !results.ready)
		else $error("event side stalled without cause");

endmodule

>>> tb/sd_card_init_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// SD card init sequencer testbench
// Runs full and broken card bring-up sessions through the event channel under
// several register settings. Every result beat is checked field by field
// against an in-bench model of the sequencer. Both channels idle and stall in
// random bursts.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer_core_tb;
	import sdci_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Timeout status codes that the sequencer treats alike.
	localparam logic [1:0] STS_TMO     = 2'd1;
	localparam logic [1:0] STS_TMO_ALT = 2'd3;
	localparam int PHASES       = 8;
	localparam int PHASE_EVENTS = 215;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	sdci_event_if  evt ();
	sdci_result_if res ();

	sd_card_init_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (evt),
		.results   (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Model copy of the settings.
	logic [1:0]  clk_sel    = 2'd0;
	logic        bus4       = 1'b0;
	logic [7:0]  poll_limit = ATTEMPT_LIMIT_RST;
	logic [19:0] tick_limit = WAIT_LIMIT_RST;

	// Model copy of the sequence state.
	step_t       seq_step   = ST_IDLE;
	logic [7:0]  poll_count = '0;
	logic [19:0] tick_count = '0;
	logic [31:0] ocr_q      = '0;
	logic        ccs_q      = 1'b0;
	logic [15:0] rca_q      = '0;
	logic        scr_second = 1'b0;

	item_t   pending_events[$];
	result_t expected_beats[$];
	item_t   cur_event;

	int  gap_left;
	int  stall_left;
	bit  quiet;
	int  errors;
	int  events_sent;
	int  beats_checked;
	int  gen_count;
	int  finishes [4];

	// ------------------------------------------------------------------
	// Sequencer model
	// ------------------------------------------------------------------

	// Push one expected beat; the capture registers are taken as they stand.
	task automatic emit(logic [1:0] kind, logic [5:0] idx, logic [31:0] arg, logic apply,
		logic [31:0] word, logic [1:0] err);
		result_t r;
		r.kind          = kind;
		r.cmd_index     = idx;
		r.cmd_argument  = arg;
		r.apply_clock   = apply;
		r.word_out      = word;
		r.error_code    = err;
		r.high_capacity = ccs_q;
		r.ocr_value     = ocr_q;
		r.card_address  = rca_q;
		expected_beats.push_back(r);
	endtask

	task automatic issue_cmd(step_t next, logic [5:0] idx, logic [31:0] arg);
		seq_step = next;
		emit(KIND_CMD, idx, arg, 1'b0, '0, ERR_NONE);
	endtask

	task automatic end_sequence(logic [1:0] err);
		seq_step = ST_IDLE;
		finishes[err]++;
		emit(KIND_FINISH, '0, '0, 1'b0, '0, err);
	endtask

	// Command completion: move to the next command or finish.
	task automatic command_done(logic [1:0] sts, logic [31:0] resp);
		logic        ok;
		logic        crc;
		logic [31:0] rarg;
		ok   = (sts == STS_OK);
		crc  = (sts == STS_CRC);
		rarg = {rca_q, 16'h0000};
		case (seq_step)
			ST_CMD0: issue_cmd(ST_CMD8, CMD_IF_COND, IF_COND_ARG);
			ST_CMD8: begin
				if (crc) begin
					end_sequence(ERR_CRC);
				end else begin
					seq_step = ST_P55;
					emit(KIND_CMD, CMD_APP, '0, 1'b0, ok ? resp : 32'h0, ERR_NONE);
				end
			end
			ST_P55: issue_cmd(ST_A41, ACMD_OP_COND, OP_COND_ARG);
			ST_A41: begin
				if (crc) begin
					end_sequence(ERR_CRC);
				end else begin
					if (poll_count < 8'd255)
						poll_count++;
					if (ok && resp[READY_POS])
						issue_cmd(ST_CMD58, CMD_READ_OCR, '0);
					else if (poll_count < poll_limit)
						issue_cmd(ST_P55, CMD_APP, '0);
					else
						end_sequence(ERR_CARD);
				end
			end
			ST_CMD58: begin
				ocr_q = ok ? resp : 32'h0;
				ccs_q = ok & resp[CCS_POS];
				if (crc) begin
					end_sequence(ERR_CRC);
				end else begin
					seq_step = ST_CMD2;
					emit(KIND_CMD, CMD_ALL_CID, '0, 1'b1, '0, ERR_NONE);
				end
			end
			ST_CMD2: begin
				if (crc)
					end_sequence(ERR_CRC);
				else
					issue_cmd(ST_CMD3, CMD_SEND_RCA, '0);
			end
			ST_CMD3: begin
				if (ok)
					rca_q = resp[31:16];
				if (crc)
					end_sequence(ERR_CRC);
				else
					issue_cmd(ST_CMD9, CMD_SEND_CSD, {rca_q, 16'h0000});
			end
			ST_CMD9: begin
				if (crc)
					end_sequence(ERR_CRC);
				else
					issue_cmd(ST_CMD7, CMD_SELECT, rarg);
			end
			ST_CMD7: begin
				if (!ccs_q)
					issue_cmd(ST_CMD16, CMD_BLOCKLEN, BLOCK_LEN);
				else
					issue_cmd(ST_B55, CMD_APP, rarg);
			end
			ST_CMD16: issue_cmd(ST_B55, CMD_APP, rarg);
			ST_B55:   issue_cmd(ST_A6, ACMD_BUS_W, bus4 ? BUS_W4_ARG : 32'h0);
			ST_A6:    issue_cmd(ST_S55, CMD_APP, rarg);
			ST_S55:   issue_cmd(ST_A51, ACMD_SEND_SCR, '0);
			ST_A51: begin
				// The SCR read starts silently.
				seq_step   = ST_SCRW;
				tick_count = '0;
				scr_second = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Apply one accepted event beat to the model.
	task automatic advance_sequence(item_t it);
		case (it.action)
			ACT_START: begin
				poll_count = '0;
				tick_count = '0;
				ocr_q      = '0;
				ccs_q      = 1'b0;
				rca_q      = '0;
				scr_second = 1'b0;
				issue_cmd(ST_CMD0, CMD_GO_IDLE, '0);
			end
			ACT_DONE: command_done(it.cmd_status, it.response_word);
			ACT_DATA: begin
				if (seq_step == ST_SCRW) begin
					tick_count = '0;
					if (scr_second)
						seq_step = ST_FINAL;
					scr_second = !scr_second;
					emit(KIND_SCR, '0, '0, 1'b0, it.data_word, ERR_NONE);
				end
			end
			default: begin
				if (seq_step == ST_FINAL)
					end_sequence(ERR_NONE);
				else if (seq_step == ST_SCRW) begin
					if (tick_count >= tick_limit)
						end_sequence(ERR_DAT);
					else
						tick_count++;
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Event driver: sends pending beats with random idle bursts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt.valid && evt.ready) begin
				advance_sequence(cur_event);
				events_sent++;
			end
			if (!evt.valid || evt.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					evt.valid <= 1'b0;
				end else if (pending_events.size() > 0) begin
					cur_event = pending_events.pop_front();
					evt.valid         <= 1'b1;
					evt.action        <= cur_event.action;
					evt.cmd_status    <= cur_event.cmd_status;
					evt.response_word <= cur_event.response_word;
					evt.data_word     <= cur_event.data_word;
					if (!quiet && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 19);
				end else begin
					evt.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random stalls, field-by-field compare.
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 40)
				$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got.kind          = res.kind;
				got.cmd_index     = res.cmd_index;
				got.cmd_argument  = res.cmd_argument;
				got.apply_clock   = res.apply_clock;
				got.word_out      = res.word_out;
				got.error_code    = res.error_code;
				got.high_capacity = res.high_capacity;
				got.ocr_value     = res.ocr_value;
				got.card_address  = res.card_address;
				if (expected_beats.size() == 0) begin
					errors++;
					if (errors <= 40)
						$display("%0t ns: unexpected result beat, expected none, actual %h",
							$time, got);
				end else begin
					want = expected_beats.pop_front();
					beats_checked++;
					check_field("kind", want.kind, got.kind);
					check_field("cmd_index", want.cmd_index, got.cmd_index);
					check_field("cmd_argument", want.cmd_argument, got.cmd_argument);
					check_field("apply_clock", want.apply_clock, got.apply_clock);
					check_field("word_out", want.word_out, got.word_out);
					check_field("error_code", want.error_code, got.error_code);
					check_field("high_capacity", want.high_capacity, got.high_capacity);
					check_field("ocr_value", want.ocr_value, got.ocr_value);
					check_field("card_address", want.card_address, got.card_address);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 19);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_item(logic [1:0] act, logic [1:0] sts, logic [31:0] resp,
		logic [31:0] data, bit counted);
		item_t it;
		it.action        = act;
		it.cmd_status    = sts;
		it.response_word = resp;
		it.data_word     = data;
		pending_events.push_back(it);
		if (counted)
			gen_count++;
	endtask

	task automatic queue_done(logic [1:0] sts, logic [31:0] resp);
		queue_item(ACT_DONE, sts, resp, $urandom, 1'b1);
	endtask

	function automatic logic [1:0] any_status();
		return 2'($urandom_range(0, 3));
	endfunction

	// Mostly ok, sometimes a CRC error or one of the timeout codes.
	function automatic logic [1:0] pick_status(int crc_odds, int tmo_odds);
		if ($urandom_range(1, crc_odds) == 1)
			return STS_CRC;
		if ($urandom_range(1, tmo_odds) == 1)
			return $urandom_range(0, 1) ? STS_TMO : STS_TMO_ALT;
		return STS_OK;
	endfunction

	// Ticks and data beats before the SCR read are ignored by the block.
	task automatic maybe_noise();
		if ($urandom_range(0, 9) == 0)
			queue_item($urandom_range(0, 1) ? ACT_TICK : ACT_DATA, any_status(),
				$urandom, $urandom, 1'b0);
	endtask

	function automatic bit cut_short();
		return $urandom_range(0, 39) == 0;
	endfunction

	// One bring-up session with random content and occasional faults.
	task automatic queue_session();
		logic [1:0]  s;
		logic [31:0] w;
		logic        cap;
		int          misses;
		int          ticks;
		queue_item(ACT_START, any_status(), $urandom, $urandom, 1'b1);
		maybe_noise();
		if (cut_short())
			return;
		queue_done(any_status(), $urandom);
		// Interface condition check.
		s = pick_status(25, 5);
		queue_done(s, $urandom_range(0, 3) == 0 ? IF_COND_ARG : $urandom);
		if (s == STS_CRC || cut_short())
			return;
		maybe_noise();
		// Operating condition poll.
		if ($urandom_range(0, 9) == 0 && (poll_limit <= 16 || $urandom_range(0, 9) == 0))
			misses = poll_limit;
		else if ($urandom_range(0, 9) == 0 && poll_limit <= 16)
			misses = poll_limit - 1;
		else
			misses = $urandom_range(0, poll_limit > 3 ? 3 : poll_limit - 1);
		for (int i = 0; i < misses; i++) begin
			queue_done(any_status(), $urandom);
			if ($urandom_range(0, 39) == 0) begin
				queue_done(STS_CRC, $urandom);
				return;
			end
			if ($urandom_range(0, 2) == 0)
				queue_done(pick_status(1000, 1), $urandom);
			else
				queue_done(STS_OK, $urandom & 32'h7FFF_FFFF);
			if (i + 1 >= poll_limit)
				return;
		end
		queue_done(any_status(), $urandom);
		queue_done(STS_OK, $urandom | 32'h8000_0000);
		if (cut_short())
			return;
		// OCR read.
		s = pick_status(30, 8);
		w = $urandom;
		cap = (s == STS_OK) && w[CCS_POS];
		queue_done(s, w);
		if (s == STS_CRC)
			return;
		maybe_noise();
		// CID, RCA and CSD.
		repeat (3) begin
			s = pick_status(30, 6);
			queue_done(s, $urandom);
			if (s == STS_CRC || cut_short())
				return;
		end
		queue_done(any_status(), $urandom);
		if (!cap)
			queue_done(any_status(), $urandom);
		maybe_noise();
		repeat (4)
			queue_done(any_status(), $urandom);
		if (cut_short())
			return;
		// SCR words, each after a few ticks; sometimes the wait runs out.
		repeat (2) begin
			if (tick_limit <= 8 && $urandom_range(0, 14) == 0) begin
				repeat (int'(tick_limit) + 1)
					queue_item(ACT_TICK, any_status(), $urandom, $urandom, 1'b1);
				return;
			end
			ticks = $urandom_range(0, tick_limit < 3 ? int'(tick_limit) : 3);
			repeat (ticks)
				queue_item(ACT_TICK, any_status(), $urandom, $urandom, 1'b1);
			queue_item(ACT_DATA, any_status(), $urandom, $urandom, 1'b1);
		end
		// A data beat in the last step is ignored; the tick finishes.
		if ($urandom_range(0, 5) == 0)
			queue_item(ACT_DATA, any_status(), $urandom, $urandom, 1'b0);
		queue_item(ACT_TICK, any_status(), $urandom, $urandom, 1'b1);
		// Stray beats while idle.
		if ($urandom_range(0, 5) == 0)
			queue_item(2'($urandom_range(1, 3)), any_status(), $urandom, $urandom, 1'b0);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_CLOCK_SELECT:  clk_sel    = data[1:0];
			REG_WIDE_BUS:      bus4       = data[0];
			REG_ATTEMPT_LIMIT: poll_limit = data[7:0];
			default:           tick_limit = data[19:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(int cs, int wb, int al, int wl);
		write_reg(REG_CLOCK_SELECT, CFG_DATA_W'(cs));
		write_reg(REG_WIDE_BUS, CFG_DATA_W'(wb));
		write_reg(REG_ATTEMPT_LIMIT, CFG_DATA_W'(al));
		write_reg(REG_WAIT_LIMIT, CFG_DATA_W'(wl));
	endtask

	// Hold off until every sent beat has been answered, then let the block settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || evt.valid || expected_beats.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Clock, stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("sd_card_init_sequencer_core_tb: done, errors");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		evt.valid = 1'b0;
		evt.action        = ACT_START;
		evt.cmd_status    = STS_OK;
		evt.response_word = '0;
		evt.data_word     = '0;
		res.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed session: strays in idle, then a high-capacity card with
		// extreme field values, timeouts on ignored and not-ready commands.
		queue_item(ACT_DONE, STS_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_item(ACT_TICK, STS_TMO_ALT, '0, '0, 1'b1);
		queue_item(ACT_DATA, STS_CRC, '0, 32'hFFFF_FFFF, 1'b1);
		queue_item(ACT_START, STS_OK, '0, '0, 1'b1);
		queue_done(STS_TMO_ALT, 32'hFFFF_FFFF);
		queue_done(STS_TMO, 32'hFFFF_FFFF);
		queue_done(STS_OK, '0);
		queue_done(STS_TMO, 32'hFFFF_FFFF);
		queue_done(STS_OK, '0);
		queue_done(STS_OK, 32'hFFFF_FFFF);
		queue_done(STS_OK, 32'hFFFF_FFFF);
		queue_done(STS_TMO, '0);
		queue_done(STS_OK, 32'hFFFF_0000);
		queue_done(STS_TMO_ALT, '0);
		queue_done(STS_CRC, '0);
		queue_done(STS_CRC, '0);
		queue_done(STS_OK, '0);
		queue_done(STS_TMO, '0);
		queue_done(STS_OK, '0);
		queue_item(ACT_TICK, STS_OK, '0, '0, 1'b1);
		queue_item(ACT_DATA, STS_OK, '0, 32'hFFFF_FFFF, 1'b1);
		queue_item(ACT_DATA, STS_OK, '0, '0, 1'b1);
		queue_item(ACT_TICK, STS_OK, '0, '0, 1'b1);
		wait_drained();

		// Random sessions under a new setting per phase.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: apply_settings(3, 1, 1, 1);
				1: apply_settings(0, 0, 255, 1048575);
				2: apply_settings(1, 1, 3, 2);
				3: apply_settings(2, 0, 200, 100000);
				default: apply_settings($urandom_range(0, 3), $urandom_range(0, 1),
					$urandom_range(1, 10), $urandom_range(1, 6));
			endcase
			quiet = (p == PHASES - 1);
			gen_count = 0;
			while (gen_count < PHASE_EVENTS)
				queue_session();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d event beats and checked %0d result beats over %0d settings.",
			events_sent, beats_checked, PHASES + 1);
		$display("Sessions ended: %0d clean, %0d CRC error, %0d not ready, %0d data timeout.",
			finishes[ERR_NONE], finishes[ERR_CRC], finishes[ERR_CARD], finishes[ERR_DAT]);
		if (errors == 0 && expected_beats.size() == 0)
			$display("sd_card_init_sequencer_core_tb: done, clean");
		else
			$display("sd_card_init_sequencer_core_tb: done, errors");
		$finish;
	end

endmodule
